// ===== hw/rtl/tfr_pkg.sv =====
package tfr_pkg;

	localparam int unsigned NAME_MAX = 40;
	localparam int unsigned NAME_CW  = 6;

	localparam logic [7:0] N_IAC  = 8'd255;
	localparam logic [7:0] N_WILL = 8'd251;
	localparam logic [7:0] N_WONT = 8'd252;
	localparam logic [7:0] N_DO   = 8'd253;
	localparam logic [7:0] N_DONT = 8'd254;
	localparam logic [7:0] S_SB   = 8'd250;
	localparam logic [7:0] O_TERM = 8'd24;
	localparam logic [7:0] O_NAWS = 8'd31;
	localparam logic [7:0] C_CR   = 8'd13;
	localparam logic [7:0] C_LF   = 8'd10;
	localparam logic [7:0] C_NUL  = 8'd0;
	localparam logic [7:0] C_UC_A = 8'd65;
	localparam logic [7:0] C_UC_Z = 8'd90;
	localparam logic [7:0] C_CASE = 8'd32;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_NAME = 2'd1,
		KIND_END  = 2'd2,
		KIND_SIZE = 2'd3
	} kind_t;

	typedef enum logic [9:0] {
		ST_DATA      = 10'b00_0000_0001,
		ST_CMD       = 10'b00_0000_0010,
		ST_OPT       = 10'b00_0000_0100,
		ST_SB        = 10'b00_0000_1000,
		ST_TERM_IS   = 10'b00_0001_0000,
		ST_TERM_NAME = 10'b00_0010_0000,
		ST_TERM_END  = 10'b00_0100_0000,
		ST_NAWS      = 10'b00_1000_0000,
		ST_SKIP      = 10'b01_0000_0000,
		ST_SKIP_LAST = 10'b10_0000_0000
	} parse_state_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  out_byte;
		logic [15:0] cols;
		logic [15:0] rows;
		logic        peer_will_term;
		logic        peer_will_naws;
	} result_t;

endpackage

// ===== hw/rtl/tfr_parser.sv =====
module tfr_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic [7:0]       item_byte,
	input  logic             dumb_mode,
	output logic             res_valid,
	output tfr_pkg::result_t res
);

	tfr_pkg::parse_state_t state_q, state_d;
	logic                         cr_seen_q, cr_seen_d;
	logic                         was_will_q, was_will_d;
	logic [2:0]                   naws_idx_q, naws_idx_d;
	logic [15:0]                  col_q, col_d;
	logic [15:0]                  row_q, row_d;
	logic [tfr_pkg::NAME_CW-1:0]  name_cnt_q, name_cnt_d;
	logic                         will_term_q, will_term_d;
	logic                         will_naws_q, will_naws_d;

	logic       is_upper;
	logic [7:0] lower_byte;

	assign is_upper   = (item_byte >= tfr_pkg::C_UC_A) && (item_byte <= tfr_pkg::C_UC_Z);
	assign lower_byte = is_upper ? item_byte + tfr_pkg::C_CASE : item_byte;

	always_comb begin
		state_d     = state_q;
		cr_seen_d   = cr_seen_q;
		was_will_d  = was_will_q;
		naws_idx_d  = naws_idx_q;
		col_d       = col_q;
		row_d       = row_q;
		name_cnt_d  = name_cnt_q;
		will_term_d = will_term_q;
		will_naws_d = will_naws_q;
		res_valid   = 1'b0;
		res.kind           = tfr_pkg::KIND_DATA;
		res.out_byte       = 8'd0;
		res.cols           = 16'd0;
		res.rows           = 16'd0;
		res.peer_will_term = will_term_q;
		res.peer_will_naws = will_naws_q;
		unique case (state_q)
			tfr_pkg::ST_CMD: begin
				state_d = tfr_pkg::ST_DATA;
				if (item_byte == tfr_pkg::N_IAC) begin
					res_valid    = 1'b1;
					res.out_byte = tfr_pkg::N_IAC;
				end else if (item_byte == tfr_pkg::S_SB) begin
					state_d = tfr_pkg::ST_SB;
				end else if (item_byte == tfr_pkg::N_WILL || item_byte == tfr_pkg::N_WONT ||
					     item_byte == tfr_pkg::N_DO || item_byte == tfr_pkg::N_DONT) begin
					was_will_d = (item_byte == tfr_pkg::N_WILL);
					state_d    = tfr_pkg::ST_OPT;
				end
			end
			tfr_pkg::ST_OPT: begin
				if (was_will_q) begin
					if (item_byte == tfr_pkg::O_TERM)
						will_term_d = 1'b1;
					else if (item_byte == tfr_pkg::O_NAWS)
						will_naws_d = 1'b1;
				end
				state_d = tfr_pkg::ST_DATA;
			end
			tfr_pkg::ST_SB: begin
				if (item_byte == tfr_pkg::O_TERM) begin
					state_d = tfr_pkg::ST_TERM_IS;
				end else if (item_byte == tfr_pkg::O_NAWS) begin
					naws_idx_d = 3'd0;
					col_d      = 16'd0;
					row_d      = 16'd0;
					state_d    = tfr_pkg::ST_NAWS;
				end else if (item_byte == tfr_pkg::N_IAC) begin
					state_d = tfr_pkg::ST_SKIP_LAST;
				end else begin
					state_d = tfr_pkg::ST_SKIP;
				end
			end
			tfr_pkg::ST_TERM_IS: begin
				name_cnt_d = '0;
				state_d    = tfr_pkg::ST_TERM_NAME;
			end
			tfr_pkg::ST_TERM_NAME: begin
				if (item_byte == tfr_pkg::N_IAC) begin
					state_d = tfr_pkg::ST_TERM_END;
				end else if (name_cnt_q < tfr_pkg::NAME_CW'(tfr_pkg::NAME_MAX)) begin
					name_cnt_d   = name_cnt_q + 1'b1;
					res_valid    = 1'b1;
					res.kind     = tfr_pkg::KIND_NAME;
					res.out_byte = lower_byte;
				end
			end
			tfr_pkg::ST_TERM_END: begin
				state_d   = tfr_pkg::ST_DATA;
				res_valid = 1'b1;
				res.kind  = tfr_pkg::KIND_END;
			end
			tfr_pkg::ST_NAWS: begin
				naws_idx_d = naws_idx_q + 3'd1;
				unique case (naws_idx_q)
					3'd0: col_d = {item_byte, 8'd0};
					3'd1: col_d = {col_q[15:8], item_byte};
					3'd2: row_d = {item_byte, 8'd0};
					3'd3: row_d = {row_q[15:8], item_byte};
					3'd4: ;
					default: begin
						naws_idx_d = 3'd0;
						state_d    = tfr_pkg::ST_DATA;
						res_valid  = 1'b1;
						res.kind   = tfr_pkg::KIND_SIZE;
						res.cols   = col_q;
						res.rows   = row_q;
					end
				endcase
			end
			tfr_pkg::ST_SKIP: begin
				if (item_byte == tfr_pkg::N_IAC)
					state_d = tfr_pkg::ST_SKIP_LAST;
			end
			tfr_pkg::ST_SKIP_LAST: begin
				state_d = tfr_pkg::ST_DATA;
			end
			default: begin
				state_d = tfr_pkg::ST_DATA;
				if (item_byte == tfr_pkg::N_IAC && !dumb_mode) begin
					state_d = tfr_pkg::ST_CMD;
				end else if (item_byte == tfr_pkg::C_CR) begin
					cr_seen_d    = 1'b1;
					res_valid    = 1'b1;
					res.out_byte = item_byte;
				end else if (item_byte == tfr_pkg::C_LF || item_byte == tfr_pkg::C_NUL) begin
					cr_seen_d    = 1'b0;
					res_valid    = !cr_seen_q;
					res.out_byte = item_byte;
				end else begin
					cr_seen_d    = 1'b0;
					res_valid    = 1'b1;
					res.out_byte = item_byte;
				end
			end
		endcase
		if (!item_valid)
			res_valid = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tfr_pkg::ST_DATA;
			cr_seen_q   <= 1'b0;
			was_will_q  <= 1'b0;
			naws_idx_q  <= 3'd0;
			col_q       <= 16'd0;
			row_q       <= 16'd0;
			name_cnt_q  <= '0;
			will_term_q <= 1'b0;
			will_naws_q <= 1'b0;
		end else if (item_valid) begin
			state_q     <= state_d;
			cr_seen_q   <= cr_seen_d;
			was_will_q  <= was_will_d;
			naws_idx_q  <= naws_idx_d;
			col_q       <= col_d;
			row_q       <= row_d;
			name_cnt_q  <= name_cnt_d;
			will_term_q <= will_term_d;
			will_naws_q <= will_naws_d;
		end
	end

	a_name_bound: assert property (@(posedge clk) disable iff (!arst_n)
		name_cnt_q <= tfr_pkg::NAME_CW'(tfr_pkg::NAME_MAX))
		else $error("name count past limit");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("parse state not one-hot");

	a_naws_exit: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && state_q == tfr_pkg::ST_NAWS && naws_idx_q == 3'd5
		|=> state_q == tfr_pkg::ST_DATA && naws_idx_q == 3'd0)
		else $error("window size sequence did not close");

	a_flags_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		will_term_q |=> will_term_q)
		else $error("terminal flag cleared");

endmodule

// ===== hw/rtl/tfr_out_buf.sv =====
module tfr_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tfr_pkg::result_t push_data,
	output logic             full,
	output logic             out_valid,
	input  logic             out_stall,
	output tfr_pkg::result_t out_data
);

	logic             out_v_q;
	logic             skid_v_q;
	tfr_pkg::result_t out_q;
	tfr_pkg::result_t skid_q;
	logic             pop;

	assign pop       = out_v_q && !out_stall;
	assign full      = skid_v_q;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || pop) begin
			out_v_q  <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || pop) begin
			out_q <= skid_v_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds an item ahead of the output register");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> !push)
		else $error("item pushed into a full buffer");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && pop |=> !skid_v_q && out_v_q)
		else $error("skid item lost on drain");

endmodule

// ===== hw/rtl/telnet_receive_filter.sv =====
// Receive-side telnet filter: one byte per item on the input channel, at most one result
// per byte on the output channel. Data bytes pass through (CR LF and CR NUL lose the
// trailing byte, IAC IAC becomes 255), telnet commands are removed, WILL TERMINAL-TYPE and
// WILL NAWS set the sticky peer flags shown on every result, a TERMINAL-TYPE
// subnegotiation yields lower-cased name characters (at most NAME_MAX) and a name end,
// and a NAWS subnegotiation yields one window size result. dumb_mode=1 treats IAC as
// data; write it only while the block is idle. Throughput is one byte per cycle while
// in_stall is low, set by the single parse step between the input register and the
// result register, which is the output register of a two-entry result buffer that holds
// results while out_stall is high; in_stall rises only when that buffer is full.
module telnet_receive_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic [15:0] cols,
	output logic [15:0] rows,
	output logic        peer_will_term,
	output logic        peer_will_naws
);

	logic             dumb_mode_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             buf_full;
	logic             advance;
	logic             in_take;
	logic             res_valid;
	tfr_pkg::result_t res;
	tfr_pkg::result_t out_data;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && !buf_full;
	assign in_stall  = valid_s1 && buf_full;
	assign in_take   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dumb_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			dumb_mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= in_byte;
		end
	end

	tfr_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (advance),
		.item_byte  (byte_s1),
		.dumb_mode  (dumb_mode_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	tfr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign kind           = out_data.kind;
	assign out_byte       = out_data.out_byte;
	assign cols           = out_data.cols;
	assign rows           = out_data.rows;
	assign peer_will_term = out_data.peer_will_term;
	assign peer_will_naws = out_data.peer_will_naws;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_held_item_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("held input item changed");

	a_result_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> advance)
		else $error("result without an input item");

endmodule

// ===== tb/sv/tb_telnet_receive_filter.sv =====
`timescale 1ns / 100ps

module tb_telnet_receive_filter;

	typedef logic [7:0] byte_q_t[$];

	localparam logic [7:0] SB_END  = 8'd240;
	localparam logic [7:0] CMD_NOP = 8'd241;
	localparam int PHASE_ITEMS = 290;
	localparam int HOLD_CYCLES = 80;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  out_byte;
	logic [15:0] cols;
	logic [15:0] rows;
	logic        peer_will_term;
	logic        peer_will_naws;

	telnet_receive_filter dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.out_byte       (out_byte),
		.cols           (cols),
		.rows           (rows),
		.peer_will_term (peer_will_term),
		.peer_will_naws (peer_will_naws)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// filter state mirror
	tfr_pkg::parse_state_t st = tfr_pkg::ST_DATA;
	logic        dumb = 1'b0;
	logic        cr_flag = 1'b0;
	logic        opt_is_will = 1'b0;
	logic [2:0]  naws_pos = 3'd0;
	logic [15:0] cols_acc = 16'd0;
	logic [15:0] rows_acc = 16'd0;
	logic [5:0]  name_len = 6'd0;
	logic        term_flag = 1'b0;
	logic        naws_flag = 1'b0;

	tfr_pkg::result_t awaited[$];
	logic [7:0] verbs [4] = '{tfr_pkg::N_WILL, tfr_pkg::N_WONT, tfr_pkg::N_DO,
		tfr_pkg::N_DONT};

	int  items_sent = 0;
	int  results_seen = 0;
	int  kind_seen [4] = '{0, 0, 0, 0};
	int  dumb_phases = 0;
	int  error_count = 0;
	logic calm = 1'b0;
	logic holding = 1'b0;
	event stall_burst;

	function automatic void add_result(tfr_pkg::kind_t k, logic [7:0] ob, logic [15:0] c,
		logic [15:0] r);
		tfr_pkg::result_t e;
		e.kind = k;
		e.out_byte = ob;
		e.cols = c;
		e.rows = r;
		e.peer_will_term = term_flag;
		e.peer_will_naws = naws_flag;
		awaited.push_back(e);
	endfunction

	function automatic void parse_byte(logic [7:0] b);
		case (st)
			tfr_pkg::ST_CMD: begin
				st = tfr_pkg::ST_DATA;
				if (b == tfr_pkg::N_IAC) begin
					add_result(tfr_pkg::KIND_DATA, tfr_pkg::N_IAC, 16'd0, 16'd0);
				end else if (b == tfr_pkg::S_SB) begin
					st = tfr_pkg::ST_SB;
				end else if (b == tfr_pkg::N_WILL || b == tfr_pkg::N_WONT ||
					b == tfr_pkg::N_DO || b == tfr_pkg::N_DONT) begin
					opt_is_will = (b == tfr_pkg::N_WILL);
					st = tfr_pkg::ST_OPT;
				end
			end
			tfr_pkg::ST_OPT: begin
				if (opt_is_will) begin
					if (b == tfr_pkg::O_TERM)
						term_flag = 1'b1;
					else if (b == tfr_pkg::O_NAWS)
						naws_flag = 1'b1;
				end
				st = tfr_pkg::ST_DATA;
			end
			tfr_pkg::ST_SB: begin
				if (b == tfr_pkg::O_TERM) begin
					st = tfr_pkg::ST_TERM_IS;
				end else if (b == tfr_pkg::O_NAWS) begin
					naws_pos = 3'd0;
					cols_acc = 16'd0;
					rows_acc = 16'd0;
					st = tfr_pkg::ST_NAWS;
				end else if (b == tfr_pkg::N_IAC) begin
					st = tfr_pkg::ST_SKIP_LAST;
				end else begin
					st = tfr_pkg::ST_SKIP;
				end
			end
			tfr_pkg::ST_TERM_IS: begin
				name_len = 6'd0;
				st = tfr_pkg::ST_TERM_NAME;
			end
			tfr_pkg::ST_TERM_NAME: begin
				if (b == tfr_pkg::N_IAC) begin
					st = tfr_pkg::ST_TERM_END;
				end else if (name_len < tfr_pkg::NAME_MAX) begin
					name_len = name_len + 6'd1;
					add_result(tfr_pkg::KIND_NAME,
						(b >= tfr_pkg::C_UC_A && b <= tfr_pkg::C_UC_Z) ?
						b + tfr_pkg::C_CASE : b,
						16'd0, 16'd0);
				end
			end
			tfr_pkg::ST_TERM_END: begin
				st = tfr_pkg::ST_DATA;
				add_result(tfr_pkg::KIND_END, 8'd0, 16'd0, 16'd0);
			end
			tfr_pkg::ST_NAWS: begin
				case (naws_pos)
					3'd0: cols_acc = {b, 8'h00};
					3'd1: cols_acc[7:0] = b;
					3'd2: rows_acc = {b, 8'h00};
					3'd3: rows_acc[7:0] = b;
					default: ;
				endcase
				if (naws_pos >= 3'd5) begin
					naws_pos = 3'd0;
					st = tfr_pkg::ST_DATA;
					add_result(tfr_pkg::KIND_SIZE, 8'd0, cols_acc, rows_acc);
				end else begin
					naws_pos = naws_pos + 3'd1;
				end
			end
			tfr_pkg::ST_SKIP: begin
				if (b == tfr_pkg::N_IAC)
					st = tfr_pkg::ST_SKIP_LAST;
			end
			tfr_pkg::ST_SKIP_LAST: begin
				st = tfr_pkg::ST_DATA;
			end
			default: begin
				st = tfr_pkg::ST_DATA;
				if (b == tfr_pkg::N_IAC && !dumb) begin
					st = tfr_pkg::ST_CMD;
				end else if (b == tfr_pkg::C_CR) begin
					cr_flag = 1'b1;
					add_result(tfr_pkg::KIND_DATA, b, 16'd0, 16'd0);
				end else if (b == tfr_pkg::C_LF || b == tfr_pkg::C_NUL) begin
					if (cr_flag)
						cr_flag = 1'b0;
					else
						add_result(tfr_pkg::KIND_DATA, b, 16'd0, 16'd0);
				end else begin
					cr_flag = 1'b0;
					add_result(tfr_pkg::KIND_DATA, b, 16'd0, 16'd0);
				end
			end
		endcase
	endfunction

	task automatic check_result();
		tfr_pkg::result_t seen;
		tfr_pkg::result_t want;
		seen.kind = tfr_pkg::kind_t'(kind);
		seen.out_byte = out_byte;
		seen.cols = cols;
		seen.rows = rows;
		seen.peer_will_term = peer_will_term;
		seen.peer_will_naws = peer_will_naws;
		results_seen++;
		kind_seen[kind]++;
		if (awaited.size() == 0) begin
			error_count++;
			if (error_count <= 10)
				$display("ERROR: unexpected item kind=%0d byte=%0d cols=%0d rows=%0d",
					kind, out_byte, cols, rows);
		end else begin
			want = awaited.pop_front();
			if (seen.kind !== want.kind || seen.out_byte !== want.out_byte ||
				seen.cols !== want.cols || seen.rows !== want.rows ||
				seen.peer_will_term !== want.peer_will_term ||
				seen.peer_will_naws !== want.peer_will_naws) begin
				error_count++;
				if (error_count <= 10)
					$display({"ERROR: item %0d exp kind=%0d byte=%0d cols=%0d rows=%0d ",
						"term=%0b naws=%0b, got kind=%0d byte=%0d cols=%0d rows=%0d ",
						"term=%0b naws=%0b"}, results_seen,
						want.kind, want.out_byte, want.cols, want.rows,
						want.peer_will_term, want.peer_will_naws,
						seen.kind, seen.out_byte, seen.cols, seen.rows,
						seen.peer_will_term, seen.peer_will_naws);
			end
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			check_result();
		out_stall <= holding || (!calm && $urandom_range(99) < 6);
	end

	always begin
		@(stall_burst);
		holding <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		holding <= 1'b0;
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (!calm && $urandom_range(99) < 3) begin
			gap = $urandom_range(3, 1);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		do @(posedge clk); while (in_stall);
		parse_byte(b);
		items_sent++;
	endtask

	task automatic send_seq(input byte_q_t seq);
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (awaited.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_dumb(input logic v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		dumb = v;
	endtask

	task automatic test_plain_data();
		write_dumb(1'b0);
		send_seq('{tfr_pkg::C_NUL, tfr_pkg::C_CR, tfr_pkg::C_LF, tfr_pkg::C_CR,
			tfr_pkg::C_NUL, tfr_pkg::C_LF, 8'h7f, 8'h80});
	endtask

	task automatic test_option_commands();
		send_seq('{tfr_pkg::N_IAC, tfr_pkg::N_IAC, tfr_pkg::N_IAC, tfr_pkg::N_WONT,
			tfr_pkg::O_TERM, tfr_pkg::N_IAC, tfr_pkg::N_WILL, tfr_pkg::O_TERM,
			tfr_pkg::N_IAC, tfr_pkg::N_DO, tfr_pkg::O_NAWS, tfr_pkg::N_IAC,
			tfr_pkg::N_WILL, tfr_pkg::O_NAWS, tfr_pkg::N_IAC, CMD_NOP});
	endtask

	task automatic test_terminal_name();
		send_seq('{tfr_pkg::N_IAC, tfr_pkg::S_SB, tfr_pkg::O_TERM, 8'd0, "@", "A", "Z",
			"[", "v", tfr_pkg::N_IAC, SB_END});
	endtask

	task automatic test_window_size();
		send_seq('{tfr_pkg::N_IAC, tfr_pkg::S_SB, tfr_pkg::O_NAWS, 8'hff, 8'hff, 8'h00,
			8'h01, tfr_pkg::N_IAC, SB_END});
	endtask

	task automatic test_other_subneg();
		send_seq('{tfr_pkg::N_IAC, tfr_pkg::S_SB, 8'd1, 8'd7, tfr_pkg::N_IAC, SB_END,
			tfr_pkg::N_IAC, tfr_pkg::S_SB, tfr_pkg::N_IAC, SB_END, "x"});
	endtask

	task automatic test_dumb_mode();
		// leave a command open across the mode change
		send_byte(tfr_pkg::N_IAC);
		drain();
		write_dumb(1'b1);
		send_seq('{tfr_pkg::N_IAC, tfr_pkg::C_CR, tfr_pkg::N_IAC, tfr_pkg::C_LF});
		drain();
		write_dumb(1'b0);
	endtask

	task automatic test_backpressure();
		-> stall_burst;
		for (int i = 0; i < 40; i++)
			send_byte(8'h61 + 8'(i % 26));
		drain();
	endtask

	task automatic random_sequence();
		byte_q_t q;
		int r;
		int n;
		int pick;
		r = $urandom_range(99);
		if (r < 40) begin
			n = $urandom_range(8, 1);
			for (int i = 0; i < n; i++) begin
				pick = $urandom_range(99);
				if (pick < 15) q.push_back(tfr_pkg::C_CR);
				else if (pick < 25) q.push_back(tfr_pkg::C_LF);
				else if (pick < 30) q.push_back(tfr_pkg::C_NUL);
				else if (pick < 35) begin
					q.push_back(tfr_pkg::N_IAC);
					q.push_back(tfr_pkg::N_IAC);
				end else q.push_back(8'($urandom_range(254)));
			end
		end else if (r < 55) begin
			q.push_back(tfr_pkg::N_IAC);
			q.push_back(verbs[$urandom_range(3)]);
			pick = $urandom_range(2);
			q.push_back(pick == 0 ? tfr_pkg::O_TERM :
				pick == 1 ? tfr_pkg::O_NAWS : 8'($urandom_range(255)));
		end else if (r < 62) begin
			q.push_back(tfr_pkg::N_IAC);
			q.push_back(8'($urandom_range(249)));
		end else if (r < 75) begin
			q = '{tfr_pkg::N_IAC, tfr_pkg::S_SB, tfr_pkg::O_TERM};
			q.push_back(8'($urandom_range(255)));
			n = ($urandom_range(99) < 15) ? $urandom_range(63) : $urandom_range(12);
			for (int i = 0; i < n; i++) begin
				pick = $urandom_range(9);
				if (pick < 5) q.push_back(tfr_pkg::C_UC_A + 8'($urandom_range(25)));
				else if (pick < 8) q.push_back(8'h61 + 8'($urandom_range(25)));
				else q.push_back(8'($urandom_range(254)));
			end
			q.push_back(tfr_pkg::N_IAC);
			q.push_back(($urandom_range(9) < 8) ? SB_END : 8'($urandom_range(255)));
		end else if (r < 87) begin
			q = '{tfr_pkg::N_IAC, tfr_pkg::S_SB, tfr_pkg::O_NAWS};
			for (int i = 0; i < 4; i++)
				q.push_back(8'($urandom_range(255)));
			if ($urandom_range(9) < 8) begin
				q.push_back(tfr_pkg::N_IAC);
				q.push_back(SB_END);
			end else begin
				q.push_back(8'($urandom_range(255)));
				q.push_back(8'($urandom_range(255)));
			end
		end else if (r < 93) begin
			q = '{tfr_pkg::N_IAC, tfr_pkg::S_SB};
			do pick = $urandom_range(255);
			while (pick == tfr_pkg::O_TERM || pick == tfr_pkg::O_NAWS);
			q.push_back(($urandom_range(19) == 0) ? tfr_pkg::N_IAC : 8'(pick));
			n = $urandom_range(6);
			for (int i = 0; i < n; i++)
				q.push_back(8'($urandom_range(254)));
			q.push_back(tfr_pkg::N_IAC);
			q.push_back(8'($urandom_range(255)));
		end else begin
			n = $urandom_range(6, 1);
			for (int i = 0; i < n; i++)
				q.push_back(8'($urandom_range(255)));
		end
		send_seq(q);
	endtask

	task automatic test_random_traffic();
		int start;
		for (int phase = 0; phase < 6; phase++) begin
			drain();
			write_dumb(phase == 1 || phase == 4);
			if (phase == 1 || phase == 4)
				dumb_phases++;
			calm <= (phase == 2);
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS)
				random_sequence();
		end
		calm <= 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_data();
		test_option_commands();
		test_terminal_name();
		test_window_size();
		test_other_subneg();
		test_dumb_mode();
		test_backpressure();
		test_random_traffic();
		drain();
		$display("Sent %0d bytes, checked %0d items (%0d dumb-mode phases).",
			items_sent, results_seen, dumb_phases);
		$display("Kinds seen: data %0d, name char %0d, name end %0d, window size %0d.",
			kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
		if (error_count == 0)
			$display("telnet_receive_filter test passed");
		else
			$display("telnet_receive_filter test failed");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("ERROR: timeout with %0d items outstanding", awaited.size());
		$display("telnet_receive_filter test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/tfr_pkg.sv
hw/rtl/tfr_parser.sv
hw/rtl/tfr_out_buf.sv
hw/rtl/telnet_receive_filter.sv
tb/sv/tb_telnet_receive_filter.sv
